// ===== sv/avdwe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avdwe_pkg
// Shared widths, codes, reset values and stage payload types of the
// audio/video drift window estimator.
// ----------------------------------------------------------------------------
package avdwe_pkg;

  localparam int unsigned TsW      = 40;  // timestamp width
  localparam int unsigned PosW     = 41;  // signed playback position
  localparam int unsigned MeanW    = 42;  // signed window mean
  localparam int unsigned OfsW     = 48;  // signed accumulated offset
  localparam int unsigned LimW     = 16;  // clamp limit and dead band
  localparam int unsigned AddW     = LimW + 2;  // signed offset increment
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 40;

  localparam int unsigned DefWindow = 36;

  localparam logic [TsW-1:0]  ResetStartTs    = '0;
  localparam logic [LimW-1:0] ResetClampLimit = 16'd5000;
  localparam logic [LimW-1:0] ResetDeadBand   = 16'd300;

  typedef enum logic [1:0] {
    OP_AUDIO = 2'd0,
    OP_VIDEO = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_TS    = 2'd0,
    CFG_CLAMP_LIMIT = 2'd1,
    CFG_DEAD_BAND   = 2'd2
  } cfg_reg_e;

  // Per-word fields that ride along the pipeline untouched.
  typedef struct packed {
    logic signed [PosW-1:0] pos;
    logic                   pos_valid;
    logic                   done;
  } item_meta_t;

endpackage
`default_nettype wire

// ===== sv/avdwe_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avdwe_acc
// Event stage: keeps the latest timestamps, accumulates audio minus video
// differences and hands the finished window sum downstream on close.
// ----------------------------------------------------------------------------
module avdwe_acc #(
  parameter int unsigned WINDOW = avdwe_pkg::DefWindow,
  localparam int unsigned SumW = avdwe_pkg::TsW + 1 + $clog2(WINDOW)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [avdwe_pkg::TsW-1:0]       start_ts_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [1:0]                      op_i,
  input  wire logic [avdwe_pkg::TsW-1:0]       timestamp_i,
  output      logic                            valid_o,
  input  wire logic                            stall_i,
  output      avdwe_pkg::item_meta_t           meta_o,
  output      logic signed [SumW-1:0]          sum_o
);
  import avdwe_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW + 1);

  logic [TsW-1:0]         audio_q, audio_d;
  logic [TsW-1:0]         video_q, video_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   valid_q;
  item_meta_t             meta_q, meta_d;
  logic signed [SumW-1:0] sum_close_q;

  logic                   accept;
  logic signed [TsW:0]    diff;
  logic signed [SumW-1:0] diff_ext;
  logic signed [PosW-1:0] pos_calc;

  assign in_stall_o = valid_q && stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign diff     = $signed({1'b0, timestamp_i}) - $signed({1'b0, video_q});
  assign diff_ext = SumW'(diff);
  assign pos_calc = $signed({1'b0, timestamp_i}) - $signed({1'b0, start_ts_i});

  always_comb begin
    audio_d = audio_q;
    video_d = video_q;
    sum_d   = sum_q;
    count_d = count_q;
    meta_d  = '0;
    if (accept) begin
      case (op_i)
        OP_AUDIO: begin
          audio_d = timestamp_i;
          if (count_q < CntW'(WINDOW)) begin
            if (video_q != '0 && timestamp_i != '0) begin
              sum_d   = sum_q + diff_ext;
              count_d = count_q + CntW'(1);
            end
          end else begin
            // The window is full: this word closes it.
            meta_d.done = 1'b1;
            sum_d       = '0;
            count_d     = '0;
          end
          if (timestamp_i != '0) begin
            meta_d.pos_valid = 1'b1;
            meta_d.pos       = pos_calc;
          end
        end
        OP_VIDEO: begin
          video_d = timestamp_i;
        end
        OP_CLEAR: begin
          audio_d = '0;
          video_d = '0;
          sum_d   = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_q <= '0;
      video_q <= '0;
      sum_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      audio_q <= audio_d;
      video_q <= video_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      if (!in_stall_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q      <= meta_d;
      sum_close_q <= sum_q;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign sum_o   = sum_close_q;

endmodule
`default_nettype wire

// ===== sv/avdwe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avdwe_div
// Window mean: divides the closed window sum by WINDOW, truncating toward
// zero, as a reciprocal multiply split into four partial products over
// three pipeline stages.
// ----------------------------------------------------------------------------
module avdwe_div #(
  parameter int unsigned WINDOW = avdwe_pkg::DefWindow,
  localparam int unsigned SumW = avdwe_pkg::TsW + 1 + $clog2(WINDOW)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  output      logic                               stall_o,
  input  wire avdwe_pkg::item_meta_t              meta_i,
  input  wire logic signed [SumW-1:0]             sum_i,
  output      logic                               valid_o,
  input  wire logic                               stall_i,
  output      avdwe_pkg::item_meta_t              meta_o,
  output      logic signed [avdwe_pkg::MeanW-1:0] mean_o
);
  import avdwe_pkg::*;

  // floor(m / WINDOW) == (m * Recip) >> Shift for every m below 2**SumW.
  localparam int unsigned Shift = SumW + $clog2(WINDOW);
  localparam int unsigned RecW  = SumW + 1;
  localparam logic [63:0] RecipFull =
      ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RecW-1:0] Recip = RecipFull[RecW-1:0];

  localparam int unsigned ML = SumW / 2;
  localparam int unsigned MH = SumW - ML;
  localparam int unsigned RL = RecW / 2;
  localparam int unsigned RH = RecW - RL;
  localparam int unsigned PW = SumW + RecW;
  localparam logic [RL-1:0] RecLo = Recip[RL-1:0];
  localparam logic [RH-1:0] RecHi = Recip[RecW-1:RL];

  logic stall2, stall3, stall4;
  logic v2_q, v3_q, v4_q;

  logic [SumW-1:0]          mag;
  logic [ML+RL-1:0]         pp_ll_q;
  logic [ML+RH-1:0]         pp_lh_q;
  logic [MH+RL-1:0]         pp_hl_q;
  logic [MH+RH-1:0]         pp_hh_q;
  logic                     neg2_q, neg3_q;
  item_meta_t               meta2_q, meta3_q, meta4_q;
  logic [PW-1:0]            full;
  logic [MeanW-1:0]         qmag_q;
  logic signed [MeanW-1:0]  mean_q;

  assign stall4  = v4_q && stall_i;
  assign stall3  = v3_q && stall4;
  assign stall2  = v2_q && stall3;
  assign stall_o = stall2;

  assign mag = sum_i[SumW-1] ? (~sum_i + SumW'(1)) : sum_i;

  assign full = (PW'(pp_hh_q) << (ML + RL)) + (PW'(pp_hl_q) << ML)
              + (PW'(pp_lh_q) << RL) + PW'(pp_ll_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (!stall2) begin
        v2_q <= valid_i;
      end
      if (!stall3) begin
        v3_q <= v2_q;
      end
      if (!stall4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall2) begin
      pp_ll_q <= (ML+RL)'(mag[ML-1:0])    * (ML+RL)'(RecLo);
      pp_lh_q <= (ML+RH)'(mag[ML-1:0])    * (ML+RH)'(RecHi);
      pp_hl_q <= (MH+RL)'(mag[SumW-1:ML]) * (MH+RL)'(RecLo);
      pp_hh_q <= (MH+RH)'(mag[SumW-1:ML]) * (MH+RH)'(RecHi);
      neg2_q  <= sum_i[SumW-1];
      meta2_q <= meta_i;
    end
    if (!stall3) begin
      qmag_q  <= full[Shift +: MeanW];
      neg3_q  <= neg2_q;
      meta3_q <= meta2_q;
    end
    if (!stall4) begin
      mean_q  <= neg3_q ? -$signed(qmag_q) : $signed(qmag_q);
      meta4_q <= meta3_q;
    end
  end

  assign valid_o = v4_q;
  assign meta_o  = meta4_q;
  assign mean_o  = mean_q;

endmodule
`default_nettype wire

// ===== sv/avdwe_ofs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avdwe_ofs
// Offset stage: clamps the window mean, takes the part beyond the dead band
// and adds it to the saturating sync offset; holds the result register.
// ----------------------------------------------------------------------------
module avdwe_ofs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [avdwe_pkg::LimW-1:0]         clamp_limit_i,
  input  wire logic [avdwe_pkg::LimW-1:0]         dead_band_i,
  input  wire logic                               valid_i,
  output      logic                               stall_o,
  input  wire avdwe_pkg::item_meta_t              meta_i,
  input  wire logic signed [avdwe_pkg::MeanW-1:0] mean_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      avdwe_pkg::item_meta_t              meta_o,
  output      logic signed [avdwe_pkg::MeanW-1:0] mean_o,
  output      logic signed [avdwe_pkg::OfsW-1:0]  offset_o
);
  import avdwe_pkg::*;

  logic stall5, stall6;
  logic v5_q, v6_q;

  logic signed [MeanW-1:0] lim_ext;
  logic signed [MeanW-1:0] clamped;
  logic signed [AddW-1:0]  c_s;
  logic signed [AddW-1:0]  band_s;
  logic signed [AddW-1:0]  add_d;

  item_meta_t              meta5_q, meta6_q;
  logic signed [MeanW-1:0] mean5_q, mean6_q;
  logic signed [AddW-1:0]  add_q;
  logic signed [OfsW-1:0]  ofs_q;
  logic signed [OfsW:0]    ofs_sum;
  logic signed [OfsW-1:0]  ofs_sat;

  assign stall6  = v6_q && out_stall_i;
  assign stall5  = v5_q && stall6;
  assign stall_o = stall5;

  assign lim_ext = $signed({{(MeanW - LimW){1'b0}}, clamp_limit_i});

  always_comb begin
    if (mean_i > lim_ext) begin
      clamped = lim_ext;
    end else if (mean_i < -lim_ext) begin
      clamped = -lim_ext;
    end else begin
      clamped = mean_i;
    end
  end

  // The clamped mean lies within the limit, so it fits the narrow width.
  assign c_s    = clamped[AddW-1:0];
  assign band_s = $signed({2'b00, dead_band_i});

  always_comb begin
    if (c_s > band_s) begin
      add_d = c_s - band_s;
    end else if (c_s < -band_s) begin
      add_d = c_s + band_s;
    end else begin
      add_d = '0;
    end
  end

  assign ofs_sum = $signed({ofs_q[OfsW-1], ofs_q}) + (OfsW+1)'(add_q);

  always_comb begin
    if (ofs_sum[OfsW] != ofs_sum[OfsW-1]) begin
      ofs_sat = ofs_sum[OfsW] ? {1'b1, {(OfsW-1){1'b0}}} : {1'b0, {(OfsW-1){1'b1}}};
    end else begin
      ofs_sat = ofs_sum[OfsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      mean6_q <= '0;
      ofs_q   <= '0;
    end else begin
      if (!stall5) begin
        v5_q <= valid_i;
      end
      if (!stall6) begin
        v6_q <= v5_q;
        if (v5_q && meta5_q.done) begin
          mean6_q <= mean5_q;
          ofs_q   <= ofs_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall5) begin
      meta5_q <= meta_i;
      mean5_q <= mean_i;
      add_q   <= add_d;
    end
    if (!stall6) begin
      meta6_q <= meta5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign meta_o      = meta6_q;
  assign mean_o      = mean6_q;
  assign offset_o    = ofs_q;

endmodule
`default_nettype wire

// ===== sv/av_drift_window_estimator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// av_drift_window_estimator_core
// Audio/video drift window estimator: playback position, windowed drift mean
// and a saturating clock-correction offset.
// ----------------------------------------------------------------------------
// The block takes one event word per clock unless in_stall_o is high, and
// returns exactly one result word for each, in order, through a pipeline of
// six registered stages. They are the event stage that keeps the
// timestamps and the window sum, three stages of the window-mean divide (a
// reciprocal multiply by 1/WINDOW done as four partial products, their sum,
// and the sign), the clamp and dead-band stage, and the result register that
// also holds the sync offset and the last window mean. A stall on the output
// stops only the stages that are full, so empty stages keep taking words.
// Configuration registers are written through a port that is always ready
// and must be written only while no event is in flight.
// ----------------------------------------------------------------------------
module av_drift_window_estimator_core #(
  parameter int unsigned WINDOW = avdwe_pkg::DefWindow
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [avdwe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [avdwe_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic [avdwe_pkg::TsW-1:0]           timestamp_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [avdwe_pkg::PosW-1:0]   position_o,
  output      logic                                position_valid_o,
  output      logic                                window_done_o,
  output      logic signed [avdwe_pkg::MeanW-1:0]  window_mean_o,
  output      logic signed [avdwe_pkg::OfsW-1:0]   sync_offset_o
);
  import avdwe_pkg::*;

  localparam int unsigned SumW = TsW + 1 + $clog2(WINDOW);

  logic [TsW-1:0]  start_ts_q;
  logic [LimW-1:0] clamp_limit_q;
  logic [LimW-1:0] dead_band_q;

  logic                    acc_valid, acc_stall;
  item_meta_t              acc_meta;
  logic signed [SumW-1:0]  acc_sum;
  logic                    div_valid, div_stall;
  item_meta_t              div_meta;
  logic signed [MeanW-1:0] div_mean;
  item_meta_t              res_meta;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ts_q    <= ResetStartTs;
      clamp_limit_q <= ResetClampLimit;
      dead_band_q   <= ResetDeadBand;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_START_TS:    start_ts_q    <= cfg_data_i[TsW-1:0];
        CFG_CLAMP_LIMIT: clamp_limit_q <= cfg_data_i[LimW-1:0];
        CFG_DEAD_BAND:   dead_band_q   <= cfg_data_i[LimW-1:0];
        default: begin
        end
      endcase
    end
  end

  avdwe_acc #(
    .WINDOW(WINDOW)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_ts_i (start_ts_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .timestamp_i(timestamp_i),
    .valid_o    (acc_valid),
    .stall_i    (acc_stall),
    .meta_o     (acc_meta),
    .sum_o      (acc_sum)
  );

  avdwe_div #(
    .WINDOW(WINDOW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(acc_valid),
    .stall_o(acc_stall),
    .meta_i (acc_meta),
    .sum_i  (acc_sum),
    .valid_o(div_valid),
    .stall_i(div_stall),
    .meta_o (div_meta),
    .mean_o (div_mean)
  );

  avdwe_ofs u_ofs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clamp_limit_i(clamp_limit_q),
    .dead_band_i  (dead_band_q),
    .valid_i      (div_valid),
    .stall_o      (div_stall),
    .meta_i       (div_meta),
    .mean_i       (div_mean),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .meta_o       (res_meta),
    .mean_o       (window_mean_o),
    .offset_o     (sync_offset_o)
  );

  assign position_o       = res_meta.pos;
  assign position_valid_o = res_meta.pos_valid;
  assign window_done_o    = res_meta.done;

endmodule
`default_nettype wire

// ===== sv/avdwe_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avdwe_chk
// Port-level checker for the drift window estimator, bound to the top level.
// ----------------------------------------------------------------------------
module avdwe_chk (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                cfg_valid_i,
  input wire logic                                cfg_ready_o,
  input wire logic [avdwe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input wire logic [avdwe_pkg::CfgDataW-1:0]      cfg_data_i,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic [1:0]                          op_i,
  input wire logic [avdwe_pkg::TsW-1:0]           timestamp_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [avdwe_pkg::PosW-1:0]   position_o,
  input wire logic                                position_valid_o,
  input wire logic                                window_done_o,
  input wire logic signed [avdwe_pkg::MeanW-1:0]  window_mean_o,
  input wire logic signed [avdwe_pkg::OfsW-1:0]   sync_offset_o
);
  import avdwe_pkg::*;

  logic                    have_prev_q;
  logic signed [OfsW-1:0]  prev_ofs_q;
  logic signed [MeanW-1:0] prev_mean_q;
  logic signed [OfsW:0]    ofs_step;
  logic                    out_take;

  assign out_take = out_valid_o && !out_stall_i;
  assign ofs_step = $signed({sync_offset_o[OfsW-1], sync_offset_o})
                  - $signed({prev_ofs_q[OfsW-1], prev_ofs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_ofs_q  <= '0;
      prev_mean_q <= '0;
    end else if (out_take) begin
      have_prev_q <= 1'b1;
      prev_ofs_q  <= sync_offset_o;
      prev_mean_q <= window_mean_o;
    end
  end

  // A held result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o)
      && $stable(window_done_o) && $stable(sync_offset_o))
    else $error("result word changed while stalled");

  // With nothing waiting at the output, no stage can be backed up.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !position_valid_o |-> position_o == '0)
    else $error("position nonzero without position_valid");

  // Mean and offset move only on words that close a window.
  a_state_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_done_o && have_prev_q
      |-> sync_offset_o == prev_ofs_q && window_mean_o == prev_mean_q)
    else $error("mean or offset changed without a window close");

  // One window close moves the offset by no more than the clamp range allows.
  a_ofs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_done_o && have_prev_q
      |-> ofs_step <= 65535 && ofs_step >= -65535)
    else $error("offset step exceeds the clamp range");

endmodule

bind av_drift_window_estimator_core avdwe_chk u_avdwe_chk (.*);
`default_nettype wire

// ===== verif/av_drift_window_estimator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av_drift_window_estimator_core_tb
// Self-checking bench for the drift window estimator. Event words are driven
// from a queue with random input gaps and output stalls. A behavioral model
// tracks the timestamps, the window sum, the mean and the offset, and every
// result word is compared field by field with the model's prediction. The
// run covers several register settings, a long output hold and a full drain.
// ----------------------------------------------------------------------------
module av_drift_window_estimator_core_tb;
  import avdwe_pkg::*;

  localparam int unsigned Window        = DefWindow;
  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam logic [TsW-1:0] MaxTs      = '1;
  localparam longint      OfsMax        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      OfsMin        = -OfsMax - 1;
  localparam int          PhaseItems    = 360;
  localparam int          HoldCycles    = 64;
  localparam int          WatchdogLimit = 5000;

  typedef struct packed {
    logic [1:0]     op;
    logic [TsW-1:0] ts;
  } evt_t;

  typedef struct packed {
    logic signed [PosW-1:0]  pos;
    logic                    pos_ok;
    logic                    done;
    logic signed [MeanW-1:0] mean;
    logic signed [OfsW-1:0]  ofs;
  } drift_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              op_i        = '0;
  logic [TsW-1:0]          timestamp_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [PosW-1:0]  position_o;
  logic                    position_valid_o;
  logic                    window_done_o;
  logic signed [MeanW-1:0] window_mean_o;
  logic signed [OfsW-1:0]  sync_offset_o;

  av_drift_window_estimator_core #(
    .WINDOW(Window)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .timestamp_i     (timestamp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .position_o      (position_o),
    .position_valid_o(position_valid_o),
    .window_done_o   (window_done_o),
    .window_mean_o   (window_mean_o),
    .sync_offset_o   (sync_offset_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Model copy of the registers and of the block's state.
  logic [TsW-1:0]  start_q = ResetStartTs;
  logic [LimW-1:0] clamp_q = ResetClampLimit;
  logic [LimW-1:0] band_q  = ResetDeadBand;
  int              win_cnt = 0;
  longint          win_sum = 0;
  logic [TsW-1:0]  audio_q = '0;
  logic [TsW-1:0]  video_q = '0;
  longint          mean_q  = 0;
  longint          ofs_q   = 0;

  evt_t          pending_events[$];
  drift_result_t predicted_results[$];

  bit idle_en   = 1'b1;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int send_gap  = 0;
  int n_queued  = 0;
  int n_sent    = 0;
  int n_results = 0;
  int n_windows = 0;
  int n_positions = 0;
  int errors    = 0;
  int quiet_cycles = 0;
  evt_t          next_evt;
  drift_result_t want;

  function automatic drift_result_t predict_event(input evt_t ev);
    drift_result_t r;
    longint lim, band, c, add, p;
    lim  = longint'(clamp_q);
    band = longint'(band_q);
    r = '0;
    case (ev.op)
      OP_AUDIO: begin
        audio_q = ev.ts;
        if (win_cnt < Window) begin
          if (audio_q != '0 && video_q != '0) begin
            win_sum = win_sum + longint'(audio_q) - longint'(video_q);
            win_cnt = win_cnt + 1;
          end
        end else begin
          // The mean is kept unclamped; only the correction sees the clamp.
          mean_q = (win_cnt == 0) ? 0 : win_sum / longint'(win_cnt);
          c = mean_q;
          if (c > lim) c = lim;
          if (c < -lim) c = -lim;
          add = 0;
          if (c > band) add = c - band;
          else if (c < -band) add = c + band;
          ofs_q = ofs_q + add;
          if (ofs_q > OfsMax) ofs_q = OfsMax;
          if (ofs_q < OfsMin) ofs_q = OfsMin;
          win_sum = 0;
          win_cnt = 0;
          r.done  = 1'b1;
        end
        if (ev.ts != '0) begin
          p        = longint'(ev.ts) - longint'(start_q);
          r.pos    = p[PosW-1:0];
          r.pos_ok = 1'b1;
        end
      end
      OP_VIDEO: video_q = ev.ts;
      OP_CLEAR: begin
        win_cnt = 0;
        win_sum = 0;
        audio_q = '0;
        video_q = '0;
      end
      default: ;
    endcase
    r.mean = mean_q[MeanW-1:0];
    r.ofs  = ofs_q[OfsW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [OfsW-1:0] got,
                                 input logic [OfsW-1:0] exp_val);
    errors++;
    $display("Mismatch on result word %0d: %s got %h, expected %h",
             n_results, field, got, exp_val);
  endtask

  // Driver: a new word is offered only once the previous one was taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      op_i        <= '0;
      timestamp_i <= '0;
      send_gap    <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        predicted_results.push_back(predict_event({op_i, timestamp_i}));
        n_sent++;
      end
      if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_events.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= $urandom_range(0, 3);
      end else begin
        next_evt    = pending_events.pop_front();
        in_valid_i  <= 1'b1;
        op_i        <= next_evt.op;
        timestamp_i <= next_evt.ts;
      end
    end
  end

  // Monitor: checks each taken result word and drives the output stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (window_done_o) n_windows++;
        if (position_valid_o) n_positions++;
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected word", '0, '0);
        end else begin
          want = predicted_results.pop_front();
          if (position_o !== want.pos)
            report_mismatch("position", OfsW'(position_o), OfsW'(want.pos));
          if (position_valid_o !== want.pos_ok)
            report_mismatch("position_valid", OfsW'(position_valid_o), OfsW'(want.pos_ok));
          if (window_done_o !== want.done)
            report_mismatch("window_done", OfsW'(window_done_o), OfsW'(want.done));
          if (window_mean_o !== want.mean)
            report_mismatch("window_mean", OfsW'(window_mean_o), OfsW'(want.mean));
          if (sync_offset_o !== want.ofs)
            report_mismatch("sync_offset", sync_offset_o, want.ofs);
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_reqs != holds_done) begin
        holds_done  <= holds_done + 1;
        hold_left   <= HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        hold_left   <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [TsW-1:0] rand_ts();
    logic [TsW-1:0] t;
    t[31:0]      = $urandom;
    t[TsW-1:32]  = 8'($urandom_range(0, 255));
    return t;
  endfunction

  task automatic push_event(input logic [1:0] op, input logic [TsW-1:0] ts);
    pending_events.push_back({op, ts});
    n_queued++;
  endtask

  // One drift window: a video reference and enough audio words to close it.
  task automatic push_window();
    logic [TsW-1:0] vts;
    logic [TsW-1:0] ats;
    longint drift;
    longint d;
    int kind;
    int n_audio;
    kind = $urandom_range(0, 19);
    if (kind < 11) drift = longint'($urandom_range(0, 18000)) - 9000;
    else if (kind < 16) drift = longint'($urandom_range(0, 160000)) - 80000;
    else if (kind < 18) drift = longint'(rand_ts()) - longint'(rand_ts());
    else drift = 0;
    if ($urandom_range(0, 3) == 0) push_event(OP_CLEAR, rand_ts());
    vts = rand_ts();
    if (kind == 18) vts = TsW'(1);
    if (kind == 19) vts = MaxTs;
    if (vts == '0) vts = TsW'(1);
    push_event(OP_VIDEO, vts);
    n_audio = Window + 1 + $urandom_range(0, 2);
    for (int i = 0; i < n_audio; i++) begin
      if (kind < 18 && $urandom_range(0, 4) == 0) begin
        vts = vts + TsW'($urandom_range(1, 40));
        if (vts == '0) vts = TsW'(1);
        push_event(OP_VIDEO, vts);
      end
      if (kind == 18) begin
        ats = MaxTs;
      end else if (kind == 19) begin
        ats = TsW'(1);
      end else begin
        d   = drift + longint'($urandom_range(0, 200)) - 100;
        ats = vts + d[TsW-1:0];
      end
      if (ats == '0) ats = TsW'(1);
      push_event(OP_AUDIO, ats);
    end
  endtask

  task automatic push_noise(input int n);
    logic [1:0]     op;
    logic [TsW-1:0] ts;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       ts = '0;
        1:       ts = MaxTs;
        default: ts = rand_ts();
      endcase
      push_event(op, ts);
    end
  endtask

  task automatic push_random(input int budget);
    int first;
    first = n_queued;
    while (n_queued - first < budget) begin
      if ($urandom_range(0, 5) == 0) push_noise($urandom_range(1, 6));
      else push_window();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_events.size() != 0 || in_valid_i || predicted_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_START_TS:    start_q = val[TsW-1:0];
      CFG_CLAMP_LIMIT: clamp_q = val[LimW-1:0];
      CFG_DEAD_BAND:   band_q  = val[LimW-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits above the 16-bit registers are random and must be ignored.
  task automatic configure(input logic [TsW-1:0] start_ts, input logic [LimW-1:0] lim,
                           input logic [LimW-1:0] band);
    logic [TsW-1:0] junk;
    write_reg(CFG_START_TS, start_ts);
    junk = rand_ts();
    write_reg(CFG_CLAMP_LIMIT, {junk[TsW-1:LimW], lim});
    junk = rand_ts();
    write_reg(CFG_DEAD_BAND, {junk[TsW-1:LimW], band});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero timestamps, unused code, clears and position ends.
    push_event(OP_AUDIO, '0);
    push_event(OP_AUDIO, MaxTs);
    push_event(OP_VIDEO, MaxTs);
    push_event(OP_AUDIO, TsW'(1));
    push_event(OpUnused, rand_ts());
    push_event(OP_VIDEO, '0);
    push_event(OP_AUDIO, TsW'(7));
    push_event(OP_CLEAR, '0);
    push_event(OP_AUDIO, rand_ts());
    push_event(OP_VIDEO, rand_ts());
    push_event(OpUnused, '0);
    push_event(OP_CLEAR, MaxTs);
    push_random(PhaseItems);
    wait_drained();

    // Widest clamp, no dead band; the output is held off to back up the input.
    configure(rand_ts(), '1, '0);
    push_random(PhaseItems);
    hold_reqs++;
    wait_drained();

    // Largest start time and zero clamp; the sender drains halfway through.
    configure(MaxTs, '0, '1);
    push_event(OP_AUDIO, TsW'(1));
    push_event(OP_AUDIO, MaxTs);
    push_random(PhaseItems / 2);
    wait_drained();
    push_random(PhaseItems / 2);
    wait_drained();

    // Dead band wider than the clamp, so the offset must stay put.
    configure(rand_ts(), 16'd1000, 16'd2000);
    push_random(PhaseItems);
    wait_drained();

    // Random limits with both sides running flat out.
    configure('0, LimW'($urandom_range(0, 65535)), LimW'($urandom_range(0, 4000)));
    idle_en = 1'b0;
    push_random(PhaseItems);
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("Covered %0d event words and %0d result words over five register settings.",
             n_sent, n_results);
    $display("%0d windows closed, %0d positions reported, final offset %0d.",
             n_windows, n_positions, ofs_q);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
